FILE: sv/cso_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// cso_pkg
// Shared types, codes and the arrow shape table for the cursor overlay.
// -----------------------------------------------------------------------------
package cso_pkg;

   // input transaction kinds
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // configuration register indexes
   localparam int          CSR_INDEX_BITS    = 3;
   localparam logic [2:0]  CSR_USE_SPRITE    = 3'd0;
   localparam logic [2:0]  CSR_CURSOR_X      = 3'd1;
   localparam logic [2:0]  CSR_CURSOR_Y      = 3'd2;
   localparam logic [2:0]  CSR_SPRITE_WIDTH  = 3'd3;
   localparam logic [2:0]  CSR_SPRITE_HEIGHT = 3'd4;
   localparam int          CSR_DATA_BITS     = 32;

   // fixed field widths
   localparam int PIX_COORD_BITS   = 12;
   localparam int SIDE_CFG_BITS    = 6;
   localparam int COLOUR_BITS      = 24;
   localparam int RGBA_BITS        = 32;
   localparam int SPRITE_DEPTH     = 1024;
   localparam int SPRITE_ADDR_BITS = 10;

   localparam logic [11:0] CURSOR_X_RESET = 12'd100;
   localparam logic [11:0] CURSOR_Y_RESET = 12'd100;
   localparam logic [5:0]  SIDE_RESET     = 6'd32;

   // built-in arrow geometry
   localparam int ARROW_W      = 12;
   localparam int ARROW_H      = 19;
   localparam int ARROW_H_BITS = 5;

   localparam logic [23:0] COLOUR_BLACK = 24'h000000;
   localparam logic [23:0] COLOUR_WHITE = 24'hFFFFFF;

   // arrow texel codes
   localparam logic [1:0] ARROW_CLEAR = 2'd0;
   localparam logic [1:0] ARROW_EDGE  = 2'd1;
   localparam logic [1:0] ARROW_FILL  = 2'd2;

   typedef struct packed {
      logic        use_sprite;
      logic [11:0] cursor_x;
      logic [11:0] cursor_y;
      logic [5:0]  sprite_width;
      logic [5:0]  sprite_height;
   } cfg_type;

   // locate stage -> blend stage
   typedef struct packed {
      logic        valid;
      logic        in_box;
      logic        sprite_mode;
      logic [1:0]  arrow_code;
      logic [23:0] background;
   } stage1_type;

   // arrow shape: leftmost column is bit 11
   function automatic logic [1:0] arrow_code(input logic [4:0] row, input logic [3:0] col);
      logic [11:0] edge_m;
      logic [11:0] fill_m;
      logic [3:0]  idx;
      edge_m = 12'b0;
      fill_m = 12'b0;
      idx    = 4'(ARROW_W - 1) - col;
      case (row)
         5'd0:  begin edge_m = 12'b1000_0000_0000; fill_m = 12'b0000_0000_0000; end
         5'd1:  begin edge_m = 12'b1100_0000_0000; fill_m = 12'b0000_0000_0000; end
         5'd2:  begin edge_m = 12'b1010_0000_0000; fill_m = 12'b0100_0000_0000; end
         5'd3:  begin edge_m = 12'b1001_0000_0000; fill_m = 12'b0110_0000_0000; end
         5'd4:  begin edge_m = 12'b1000_1000_0000; fill_m = 12'b0111_0000_0000; end
         5'd5:  begin edge_m = 12'b1000_0100_0000; fill_m = 12'b0111_1000_0000; end
         5'd6:  begin edge_m = 12'b1000_0010_0000; fill_m = 12'b0111_1100_0000; end
         5'd7:  begin edge_m = 12'b1000_0001_0000; fill_m = 12'b0111_1110_0000; end
         5'd8:  begin edge_m = 12'b1000_0000_1000; fill_m = 12'b0111_1111_0000; end
         5'd9:  begin edge_m = 12'b1000_0000_0100; fill_m = 12'b0111_1111_1000; end
         5'd10: begin edge_m = 12'b1000_0011_1110; fill_m = 12'b0111_1100_0000; end
         5'd11: begin edge_m = 12'b1000_1000_0000; fill_m = 12'b0111_0000_0000; end
         5'd12: begin edge_m = 12'b1001_1000_0000; fill_m = 12'b0110_0000_0000; end
         5'd13: begin edge_m = 12'b1010_1000_0000; fill_m = 12'b0101_0000_0000; end
         5'd14: begin edge_m = 12'b1001_0100_0000; fill_m = 12'b0100_1000_0000; end
         5'd15: begin edge_m = 12'b1000_1010_0000; fill_m = 12'b0000_0100_0000; end
         5'd16: begin edge_m = 12'b0000_1010_0000; fill_m = 12'b0000_0100_0000; end
         5'd17: begin edge_m = 12'b0000_0100_0000; fill_m = 12'b0000_0000_0000; end
         default: begin edge_m = 12'b0; fill_m = 12'b0; end
      endcase
      if (col > 4'(ARROW_W - 1)) begin
         return ARROW_CLEAR;
      end else if (edge_m[idx]) begin
         return ARROW_EDGE;
      end else if (fill_m[idx]) begin
         return ARROW_FILL;
      end
      return ARROW_CLEAR;
   endfunction

endpackage
`default_nettype wire

FILE: sv/cso_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// cso_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// -----------------------------------------------------------------------------
module cso_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sv/cso_locate.sv
`default_nettype none
// -----------------------------------------------------------------------------
// cso_locate
// First pipeline stage: cursor box test, sprite address and arrow lookup.
// -----------------------------------------------------------------------------
module cso_locate #(
   parameter int SPRITE_MAX_SIDE   = 32,
   parameter int SCREEN_COORD_BITS = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   pixel_fire,
   input  wire cso_pkg::cfg_type       cfg,
   input  wire logic [11:0]            pixel_x,
   input  wire logic [11:0]            pixel_y,
   input  wire logic [23:0]            background,
   output logic      [9:0]             rd_addr,
   output cso_pkg::stage1_type         s1
);
   import cso_pkg::*;

   localparam int SideBits = $clog2(SPRITE_MAX_SIDE + 1);
   localparam int BoxBits  = (SideBits > ARROW_H_BITS) ? SideBits : ARROW_H_BITS;
   localparam int CmpBits  = (SCREEN_COORD_BITS > BoxBits) ? SCREEN_COORD_BITS : BoxBits;
   localparam int ProdBits = 2 * SideBits + 1;

   logic [SCREEN_COORD_BITS-1:0] px, py, cx, cy, col, row;
   logic [SideBits-1:0]          spr_w, spr_h;
   logic [BoxBits-1:0]           box_w, box_h;
   logic [ProdBits-1:0]          lin_addr;
   logic                         in_box;
   stage1_type                   s1_ff, s1_in;

   // screen geometry, masked to the screen coordinate width
   always_comb begin
      px = SCREEN_COORD_BITS'(pixel_x);
      py = SCREEN_COORD_BITS'(pixel_y);
      cx = SCREEN_COORD_BITS'(cfg.cursor_x);
      cy = SCREEN_COORD_BITS'(cfg.cursor_y);
      col = px - cx;
      row = py - cy;
   end

   // saturate sprite size, pick box size by mode
   always_comb begin
      spr_w = (CmpBits'(cfg.sprite_width) > CmpBits'(SPRITE_MAX_SIDE))
              ? SideBits'(SPRITE_MAX_SIDE) : SideBits'(cfg.sprite_width);
      spr_h = (CmpBits'(cfg.sprite_height) > CmpBits'(SPRITE_MAX_SIDE))
              ? SideBits'(SPRITE_MAX_SIDE) : SideBits'(cfg.sprite_height);
      box_w = cfg.use_sprite ? BoxBits'(spr_w) : BoxBits'(ARROW_W);
      box_h = cfg.use_sprite ? BoxBits'(spr_h) : BoxBits'(ARROW_H);
      in_box = (px >= cx) && (py >= cy)
               && (CmpBits'(col) < CmpBits'(box_w))
               && (CmpBits'(row) < CmpBits'(box_h));
   end

   // sprite entry address, wrapped to the store depth
   always_comb begin
      lin_addr = ProdBits'(row[SideBits-1:0]) * ProdBits'(spr_w)
                 + ProdBits'(col[SideBits-1:0]);
      rd_addr  = SPRITE_ADDR_BITS'(lin_addr);
   end

   // next stage contents
   always_comb begin
      s1_in.valid       = pixel_fire;
      s1_in.in_box      = in_box;
      s1_in.sprite_mode = cfg.use_sprite;
      s1_in.arrow_code  = arrow_code(row[ARROW_H_BITS-1:0], col[3:0]);
      s1_in.background  = background;
   end

   // advance stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff <= s1_in;
      end
   end

   assign s1 = s1_ff;

endmodule
`default_nettype wire

FILE: sv/cso_blend.sv
`default_nettype none
// -----------------------------------------------------------------------------
// cso_blend
// Second and third pipeline stages: alpha products, divide by 255, select.
// -----------------------------------------------------------------------------
module cso_blend (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance2,
   input  wire logic                advance3,
   input  wire cso_pkg::stage1_type s1,
   input  wire logic [31:0]         sprite_word,
   output logic                     s2_valid,
   output logic                     out_valid,
   output logic [23:0]              out_pixel,
   output logic                     out_hit
);
   import cso_pkg::*;

   typedef struct packed {
      logic             valid;
      logic             blend_sel;
      logic             hit;
      logic [2:0][15:0] sum;
      logic [23:0]      colour;
   } stage2_type;

   stage2_type  s2_ff, s2_in;
   logic        out_valid_ff;
   logic [23:0] out_pixel_ff, out_pixel_in;
   logic        out_hit_ff;
   logic [7:0]  alpha, alpha_inv;

   // exact x/255 for x up to 255*255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'(x >> 8) + 17'd1;
      return t[15:8];
   endfunction

   // alpha products per channel, arrow colour select
   always_comb begin
      alpha     = sprite_word[7:0];
      alpha_inv = 8'hFF - alpha;
      s2_in.valid     = s1.valid;
      s2_in.blend_sel = 1'b0;
      s2_in.hit       = 1'b0;
      s2_in.colour    = s1.background;
      for (int c = 0; c < 3; c++) begin
         s2_in.sum[c] = 16'(sprite_word[8 + 8*c +: 8]) * 16'(alpha)
                        + 16'(s1.background[8*c +: 8]) * 16'(alpha_inv);
      end
      if (s1.in_box && s1.sprite_mode) begin
         s2_in.blend_sel = 1'b1;
         s2_in.hit       = (alpha != 8'd0);
      end else if (s1.in_box) begin
         case (s1.arrow_code)
            ARROW_EDGE: begin
               s2_in.colour = COLOUR_BLACK;
               s2_in.hit    = 1'b1;
            end
            ARROW_FILL: begin
               s2_in.colour = COLOUR_WHITE;
               s2_in.hit    = 1'b1;
            end
            default: begin
               s2_in.colour = s1.background;
               s2_in.hit    = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (advance2) begin
         s2_ff <= s2_in;
      end
   end

   // divide sums and pick the final colour
   always_comb begin
      out_pixel_in = s2_ff.colour;
      if (s2_ff.blend_sel) begin
         for (int c = 0; c < 3; c++) begin
            out_pixel_in[8*c +: 8] = div255(s2_ff.sum[c]);
         end
      end
   end

   // output register, held while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance3) begin
         out_valid_ff <= s2_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance3) begin
         out_pixel_ff <= out_pixel_in;
         out_hit_ff   <= s2_ff.hit;
      end
   end

   assign s2_valid  = s2_ff.valid;
   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;
   assign out_hit   = out_hit_ff;

   // a stalled stage two keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      s2_ff.valid && !advance3 |=> s2_ff.valid && $stable(s2_ff.sum))
      else $error("stage two lost data on stall");

   // an uncovered pixel leaves the background untouched
   assert property (@(posedge clock) disable iff (reset)
      advance2 && s1.valid && !s1.in_box |=> !s2_ff.hit && !s2_ff.blend_sel)
      else $error("hit outside cursor box");

   // each result comes from a valid stage two entry
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s2_ff.valid))
      else $error("result without a transaction");

endmodule
`default_nettype wire

FILE: sv/cursor_sprite_alpha_overlay.sv
`default_nettype none
// -----------------------------------------------------------------------------
// cursor_sprite_alpha_overlay
// Lays a hardware cursor (RGBA sprite or built-in arrow) over scanout pixels.
// -----------------------------------------------------------------------------
// Usage:
//   req_*  carries one transaction per handshake: a sprite load (operation 0,
//          writes req_sprite_rgba at req_sprite_index, no result) or a pixel
//          (operation 1, screen position and background colour).
//   rsp_*  returns one result per pixel: the overlaid colour and a hit flag.
//   csr_*  writes the mode, cursor position and sprite size registers; always
//          ready; to be written only while the pipeline is empty (not enforced).
//   A pixel passes three registered stages to rsp_valid: box test and sprite
//   RAM read, alpha products, divide by 255 and output register. Throughput
//   is one transaction per cycle while rsp_ready is high; each stage holds a
//   valid bit and advances whenever the stage after it is empty or moving,
//   so bubbles close up. When rsp_ready is low the output register holds its
//   result and the stages behind it keep filling; req_ready drops only once
//   all three are full. Reset clears the valid bits and restores the register
//   defaults; sprite RAM contents are undefined until loaded.
// -----------------------------------------------------------------------------
module cursor_sprite_alpha_overlay #(
   parameter int SPRITE_MAX_SIDE   = 32,
   parameter int SCREEN_COORD_BITS = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire logic [9:0]  req_sprite_index,
   input  wire logic [31:0] req_sprite_rgba,
   input  wire logic [11:0] req_pixel_x,
   input  wire logic [11:0] req_pixel_y,
   input  wire logic [23:0] req_background,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [23:0]      rsp_out_pixel,
   output logic             rsp_cursor_hit,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import cso_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   stage1_type  s1;
   logic [9:0]  rd_addr;
   logic [31:0] sprite_word;
   logic        adv1, adv2, adv3;
   logic        s2_valid;
   logic        req_fire, load_fire, pixel_fire;

   // stage enables: a stage moves when the next one is empty or moving
   assign adv3       = !rsp_valid || rsp_ready;
   assign adv2       = !s2_valid || adv3;
   assign adv1       = !s1.valid || adv2;
   assign req_ready  = adv1;
   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (req_operation == OP_LOAD);
   assign pixel_fire = req_fire && (req_operation == OP_PIXEL);
   assign csr_ready  = 1'b1;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_USE_SPRITE:    cfg_in.use_sprite    = csr_wdata[0];
            CSR_CURSOR_X:      cfg_in.cursor_x      = csr_wdata[11:0];
            CSR_CURSOR_Y:      cfg_in.cursor_y      = csr_wdata[11:0];
            CSR_SPRITE_WIDTH:  cfg_in.sprite_width  = csr_wdata[5:0];
            CSR_SPRITE_HEIGHT: cfg_in.sprite_height = csr_wdata[5:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.use_sprite    <= 1'b0;
         cfg_ff.cursor_x      <= CURSOR_X_RESET;
         cfg_ff.cursor_y      <= CURSOR_Y_RESET;
         cfg_ff.sprite_width  <= SIDE_RESET;
         cfg_ff.sprite_height <= SIDE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cso_locate #(
      .SPRITE_MAX_SIDE   (SPRITE_MAX_SIDE),
      .SCREEN_COORD_BITS (SCREEN_COORD_BITS)
   ) u_locate (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv1),
      .pixel_fire (pixel_fire),
      .cfg        (cfg_ff),
      .pixel_x    (req_pixel_x),
      .pixel_y    (req_pixel_y),
      .background (req_background),
      .rd_addr    (rd_addr),
      .s1         (s1)
   );

   // sprite store: loads write, pixels read alongside stage one
   cso_ram #(
      .WIDTH (RGBA_BITS),
      .DEPTH (SPRITE_DEPTH)
   ) u_sprite_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (req_sprite_index),
      .wr_data (req_sprite_rgba),
      .rd_en   (adv1),
      .rd_addr (rd_addr),
      .rd_data (sprite_word)
   );

   cso_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .advance2    (adv2),
      .advance3    (adv3),
      .s1          (s1),
      .sprite_word (sprite_word),
      .s2_valid    (s2_valid),
      .out_valid   (rsp_valid),
      .out_pixel   (rsp_out_pixel),
      .out_hit     (rsp_cursor_hit)
   );

   // a pixel transaction always lands in stage one
   assert property (@(posedge clock) disable iff (reset)
      pixel_fire |=> s1.valid)
      else $error("pixel transaction dropped at entry");

   // a load transaction never occupies the pipeline
   assert property (@(posedge clock) disable iff (reset)
      load_fire |=> !s1.valid)
      else $error("load transaction entered the pipeline");

   // a stalled stage one keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      s1.valid && !adv2 |=> s1.valid && $stable(s1.background) && $stable(sprite_word))
      else $error("stage one lost data on stall");

endmodule
`default_nettype wire
